// ----- rtl/core/stc_pkg.sv -----
// shared types, constants and functions of the segment turn cost block
package stc_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam int CW     = 46;
    localparam int DW     = 31;
    localparam int RZW    = 34;
    localparam int WW     = 24;
    localparam int GW     = 22;
    localparam int MAG_W  = 45;
    localparam int LO_W   = 23;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int COST_W = 48;
    localparam int CFG_IW = 2;

    localparam logic [19:0]   PI4_Q20     = 20'd823550;
    localparam logic [DW-1:0] SMALL_ANGLE = 31'd6836;

    localparam logic [CFG_IW-1:0] CFG_TURN_W = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HEAD_A = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HEAD_B = 2'd2;

    localparam logic [WW-1:0] WEIGHT_RESET = 24'd65536;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [DW-1:0] d;
    } t_item;

    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // squared cordic gain in q.30, evaluated at elaboration
    function automatic logic [63:0] gain_prod(input int n);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < n; i++) begin
            p = p + (p >> (2 * i));
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/stc_front.sv -----
// front end: coordinate differences, vectoring cordic and angle fold
module stc_front #(
    parameter int STEPS = stc_pkg::CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_start_x,
    input  logic signed [31:0]  i_start_y,
    input  logic signed [31:0]  i_end_x,
    input  logic signed [31:0]  i_end_y,
    input  logic [31:0]         i_travel_angle,
    output logic                o_valid,
    output stc_pkg::t_item      o_item,
    input  logic                i_ready
);

    localparam int CW = stc_pkg::CW;
    localparam int DW = stc_pkg::DW;

    logic                 en;
    logic [STEPS:0]       r_v;
    logic signed [CW-1:0] r_x   [0:STEPS];
    logic signed [CW-1:0] r_y   [0:STEPS];
    logic [31:0]          r_seg [0:STEPS];
    logic [31:0]          r_ta  [0:STEPS];

    logic signed [32:0]   dx, dy;
    logic signed [CW-1:0] x0, y0;
    logic                 neg;
    logic [31:0]          diff;
    logic [DW-1:0]        rfold;

    assign en         = !r_v[STEPS] || i_ready;
    assign o_in_ready = en;

    assign dx  = 33'(i_start_x) - 33'(i_end_x);
    assign dy  = 33'(i_start_y) - 33'(i_end_y);
    assign x0  = {{(CW-41){dx[32]}}, dx, 8'd0};
    assign y0  = {{(CW-41){dy[32]}}, dy, 8'd0};
    assign neg = x0[CW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[STEPS-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]   <= neg ? -x0 : x0;
            r_y[0]   <= neg ? -y0 : y0;
            r_seg[0] <= neg ? 32'h8000_0000 : 32'h0;
            r_ta[0]  <= i_travel_angle;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_vec
        logic signed [CW-1:0] xs, ys;
        logic                 up;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        assign up = r_y[k] > 0;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (up) begin
                    r_x[k+1]   <= r_x[k] + ys;
                    r_y[k+1]   <= r_y[k] - xs;
                    r_seg[k+1] <= r_seg[k] + stc_pkg::atan_tab(k);
                end else begin
                    r_x[k+1]   <= r_x[k] - ys;
                    r_y[k+1]   <= r_y[k] + xs;
                    r_seg[k+1] <= r_seg[k] - stc_pkg::atan_tab(k);
                end
                r_ta[k+1] <= r_ta[k];
            end
        end
    end

    // fold modulo half turn and take the magnitude
    assign diff  = r_ta[STEPS] - r_seg[STEPS];
    assign rfold = diff[DW-1:0];

    always_comb begin
        o_item.x = r_x[STEPS];
        if (rfold[DW-1]) begin
            o_item.d = DW'(32'h8000_0000 - {1'b0, rfold});
        end else begin
            o_item.d = rfold;
        end
    end

    assign o_valid = r_v[STEPS];

endmodule

// ----- rtl/core/stc_fifo.sv -----
// small register queue between front and back
module stc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/core/stc_back.sv -----
// back end: rotation cordic, gain correction and weighted cost
module stc_back #(
    parameter int STEPS = stc_pkg::CORDIC_STEPS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  stc_pkg::t_item               i_item,
    input  logic [stc_pkg::WW-1:0]       i_turn_weight,
    input  logic [stc_pkg::WW-1:0]       i_headland_weight_a,
    input  logic [stc_pkg::WW-1:0]       i_headland_weight_b,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [stc_pkg::COST_W-1:0]   o_cost
);

    localparam int CW    = stc_pkg::CW;
    localparam int RZW   = stc_pkg::RZW;
    localparam int GW    = stc_pkg::GW;
    localparam int MAG_W = stc_pkg::MAG_W;
    localparam int LO_W  = stc_pkg::LO_W;
    localparam int HI_W  = stc_pkg::HI_W;
    localparam int WW    = stc_pkg::WW;
    localparam int LAST  = STEPS + 6;
    localparam logic [63:0]   GAIN_P   = stc_pkg::gain_prod(STEPS);
    localparam logic [GW-1:0] GAIN_INV = GW'((64'd1 << 52) / GAIN_P);

    logic                  en;
    logic [LAST:0]         r_v;
    logic signed [CW-1:0]  r_rx [0:STEPS];
    logic signed [CW-1:0]  r_ry [0:STEPS];
    logic signed [RZW-1:0] r_rz [0:STEPS];
    logic                  r_sm [0:STEPS+2];

    logic [MAG_W-1:0]      cmag, smag;
    logic [LO_W+GW-1:0]    r_pc_lo, r_ps_lo;
    logic [HI_W+GW-1:0]    r_pc_hi, r_ps_hi;
    logic [MAG_W-1:0]      r_lcos, r_lsin;
    logic [LO_W+19:0]      r_pt_lo;
    logic [HI_W+19:0]      r_pt_hi;
    logic [MAG_W-10:0]     r_head3, r_head4;
    logic [36:0]           r_turn;
    logic [60:0]           r_m1, r_m2;
    logic [MAG_W+GW-1:0]   lcos_sum, lsin_sum;
    logic [64:0]           turn_sum;
    logic [61:0]           cost_sum;
    logic [WW:0]           head_w;

    assign en          = !r_v[LAST] || i_out_ready;
    assign o_pop       = en;
    assign o_out_valid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0] <= signed'(i_item.x);
            r_ry[0] <= '0;
            r_rz[0] <= signed'(RZW'(i_item.d));
            r_sm[0] <= i_item.d < stc_pkg::SMALL_ANGLE;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_rot
        logic signed [CW-1:0]  xs, ys;
        logic signed [RZW-1:0] at;
        assign xs = r_rx[k] >>> k;
        assign ys = r_ry[k] >>> k;
        assign at = signed'(RZW'(stc_pkg::atan_tab(k)));
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_rz[k][RZW-1]) begin
                    r_rx[k+1] <= r_rx[k] - ys;
                    r_ry[k+1] <= r_ry[k] + xs;
                    r_rz[k+1] <= r_rz[k] - at;
                end else begin
                    r_rx[k+1] <= r_rx[k] + ys;
                    r_ry[k+1] <= r_ry[k] - xs;
                    r_rz[k+1] <= r_rz[k] + at;
                end
                r_sm[k+1] <= r_sm[k];
            end
        end
    end

    // negative sine is rotation slack
    assign cmag = MAG_W'(r_rx[STEPS][CW-1] ? -r_rx[STEPS] : r_rx[STEPS]);
    assign smag = r_ry[STEPS][CW-1] ? '0 : MAG_W'(r_ry[STEPS]);

    assign lcos_sum = {r_pc_hi, {LO_W{1'b0}}} + (MAG_W+GW)'(r_pc_lo);
    assign lsin_sum = {r_ps_hi, {LO_W{1'b0}}} + (MAG_W+GW)'(r_ps_lo);
    assign turn_sum = {r_pt_hi, {LO_W{1'b0}}} + 65'(r_pt_lo);
    assign head_w   = {1'b0, i_headland_weight_a} + {1'b0, i_headland_weight_b};
    assign cost_sum = 62'(r_m1) + 62'(r_m2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pc_lo      <= cmag[LO_W-1:0] * GAIN_INV;
            r_pc_hi      <= cmag[MAG_W-1:LO_W] * GAIN_INV;
            r_ps_lo      <= smag[LO_W-1:0] * GAIN_INV;
            r_ps_hi      <= smag[MAG_W-1:LO_W] * GAIN_INV;
            r_sm[STEPS+1] <= r_sm[STEPS];

            r_lcos       <= lcos_sum[MAG_W+GW-1:GW];
            r_lsin       <= lsin_sum[MAG_W+GW-1:GW];
            r_sm[STEPS+2] <= r_sm[STEPS+1];

            r_pt_lo      <= r_lsin[LO_W-1:0] * stc_pkg::PI4_Q20;
            r_pt_hi      <= r_lsin[MAG_W-1:LO_W] * stc_pkg::PI4_Q20;
            r_head3      <= r_sm[STEPS+2] ? '0 : r_lcos[MAG_W-1:9];

            r_turn       <= turn_sum[64:28];
            r_head4      <= r_head3;

            r_m1         <= i_turn_weight * r_turn;
            r_m2         <= head_w * r_head4;

            o_cost       <= {2'b00, cost_sum[61:16]};
        end
    end

endmodule

// ----- rtl/core/segment_turn_cost_top.sv -----
// top level of the segment turn cost block
// Use: each input transaction carries one segment (start and end points,
// signed Q16.16) and a travel direction as a 32-bit binary angle. Each
// one gives exactly one output transaction with the weighted cost,
// unsigned Q32.16, in input order.
// Channels: valid/ready on input and output; the user is to write weights
// through i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle;
// the block itself does not enforce this. Throughput: one transaction per
// cycle while i_out_ready is high, set by the fully pipelined vectoring and
// rotation cordic stages. Pipeline: CORDIC_STEPS+1 front stages, the
// four-entry queue, then CORDIC_STEPS+7 back stages.
// Reset (synchronous, active low) empties the pipelines and the queue and
// sets every weight to 1.0.
// Receiver stall: the back pipeline holds; the front keeps running into a
// four-entry queue and drops input ready only once that queue is full.
module segment_turn_cost_top #(
    parameter int CORDIC_STEPS = stc_pkg::CORDIC_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stc_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [stc_pkg::WW-1:0]        i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_start_x,
    input  logic signed [31:0]            i_start_y,
    input  logic signed [31:0]            i_end_x,
    input  logic signed [31:0]            i_end_y,
    input  logic [31:0]                   i_travel_angle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [stc_pkg::COST_W-1:0]    o_cost
);

    localparam int IW = $bits(stc_pkg::t_item);

    logic [stc_pkg::WW-1:0] r_turn_w, r_head_a, r_head_b;
    logic                   f_valid, f_ready, q_valid, q_pop;
    stc_pkg::t_item         f_item, q_item;
    logic [IW-1:0]          q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_w <= stc_pkg::WEIGHT_RESET;
            r_head_a <= stc_pkg::WEIGHT_RESET;
            r_head_b <= stc_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stc_pkg::CFG_TURN_W: r_turn_w <= i_cfg_data;
                stc_pkg::CFG_HEAD_A: r_head_a <= i_cfg_data;
                stc_pkg::CFG_HEAD_B: r_head_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stc_front #(.STEPS(CORDIC_STEPS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_travel_angle (i_travel_angle),
        .o_valid        (f_valid),
        .o_item         (f_item),
        .i_ready        (f_ready)
    );

    stc_fifo #(.W(IW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign q_item = q_data;

    stc_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (q_valid),
        .o_pop               (q_pop),
        .i_item              (q_item),
        .i_turn_weight       (r_turn_w),
        .i_headland_weight_a (r_head_a),
        .i_headland_weight_b (r_head_b),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_cost              (o_cost)
    );

endmodule

// ----- tb/tb_segment_turn_cost_top.sv -----
// testbench for the segment turn cost block: random and directed segments against a predictor
`timescale 1ns / 1ps

module tb_segment_turn_cost_top;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [31:0]        ang;
    } t_segment;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [stc_pkg::CFG_IW-1:0] i_cfg_idx = '0;
    logic [stc_pkg::WW-1:0]     i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic [31:0]       i_travel_angle = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [stc_pkg::COST_W-1:0] o_cost;

    segment_turn_cost_top dut (.*);

    always #1 i_clk = ~i_clk;

    logic [stc_pkg::WW-1:0] turn_w = stc_pkg::WEIGHT_RESET;
    logic [stc_pkg::WW-1:0] head_wa = stc_pkg::WEIGHT_RESET;
    logic [stc_pkg::WW-1:0] head_wb = stc_pkg::WEIGHT_RESET;
    t_segment          seg_queue[$];
    logic [stc_pkg::COST_W-1:0] cost_queue[$];
    int  n_errors = 0;
    bit  in_taken = 0;
    bit  quiet_src = 0, quiet_snk = 0, hold_snk = 0, src_pause = 0;

    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [stc_pkg::COST_W-1:0] segment_cost(input t_segment s);
        logic signed [63:0] x, y, xs, ys, rx, ry, rz;
        logic [31:0] seg_ang, diff, r, d;
        logic [63:0] p, g, cmag, smag, lcos, lsin, turn, head;
        logic [127:0] sum, cst;
        x = (64'(s.sx) - 64'(s.ex)) * 256;
        y = (64'(s.sy) - 64'(s.ey)) * 256;
        seg_ang = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            seg_ang = 32'h80000000;
        end
        for (int i = 0; i < stc_pkg::CORDIC_STEPS; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; seg_ang = seg_ang + stc_pkg::atan_tab(i);
            end else begin
                x = x - ys; y = y + xs; seg_ang = seg_ang - stc_pkg::atan_tab(i);
            end
        end
        diff = s.ang - seg_ang;
        r = diff & 32'h7FFFFFFF;
        d = (r >= 32'h40000000) ? (32'h80000000 - r) : r;
        rx = x; ry = 0; rz = 64'(d);
        for (int i = 0; i < stc_pkg::CORDIC_STEPS; i++) begin
            xs = shr(rx, i);
            ys = shr(ry, i);
            if (rz >= 0) begin
                rx = rx - ys; ry = ry + xs; rz = rz - 64'(stc_pkg::atan_tab(i));
            end else begin
                rx = rx + ys; ry = ry - xs; rz = rz + 64'(stc_pkg::atan_tab(i));
            end
        end
        cmag = rx < 0 ? -rx : rx;
        smag = ry < 0 ? 0 : ry;
        p = 64'd1 << 30;
        for (int i = 0; i < stc_pkg::CORDIC_STEPS; i++) p = p + (p >> (2 * i));
        g = (64'd1 << 52) / p;
        lcos = (cmag * g) >> 22;
        lsin = (smag * g) >> 22;
        turn = ((lsin * 64'd823550) >> 20) >> 8;
        head = (d < 32'd6836) ? 0 : (lcos >> 9);
        sum = 128'(turn_w) * 128'(turn) + (128'(head_wa) + 128'(head_wb)) * 128'(head);
        cst = sum >> 16;
        if (cst > 128'hFFFFFFFFFFFF) cst = 128'hFFFFFFFFFFFF;
        return cst[stc_pkg::COST_W-1:0];
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (seg_queue.size() > 0 && !src_pause &&
                    (quiet_src || $urandom_range(99) >= 21)) begin
                    i_in_valid     <= 1'b1;
                    i_start_x      <= seg_queue[0].sx;
                    i_start_y      <= seg_queue[0].sy;
                    i_end_x        <= seg_queue[0].ex;
                    i_end_y        <= seg_queue[0].ey;
                    i_travel_angle <= seg_queue[0].ang;
                    cost_queue.push_back(segment_cost(seg_queue.pop_front()));
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !hold_snk && (quiet_snk || $urandom_range(99) >= 21);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cost_queue.size() == 0) begin
                n_errors = n_errors + 1;
                if (n_errors <= 10) $display("unexpected transaction, cost %h", o_cost);
            end else begin
                if (o_cost !== cost_queue[0]) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                        $display("cost mismatch: expected %h actual %h", cost_queue[0], o_cost);
                end
                void'(cost_queue.pop_front());
            end
        end
    end

    function automatic t_segment rand_segment(input int kind);
        t_segment s;
        logic [31:0] m;
        m = (kind == 0) ? 32'hFFFFFFFF : (32'hFFFFFFFF >> $urandom_range(31));
        s.sx = $urandom & m; s.sy = $urandom & m;
        s.ex = $urandom & m; s.ey = $urandom & m;
        if ($urandom_range(3) == 0) begin
            s.ex = s.sx; s.ey = s.sy;
        end
        s.ang = $urandom;
        if ($urandom_range(3) == 0) s.ang = $urandom_range(8000);
        return s;
    endfunction

    task automatic drain();
        wait (seg_queue.size() == 0 && cost_queue.size() == 0);
        repeat (3 * stc_pkg::CORDIC_STEPS + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [stc_pkg::CFG_IW-1:0] idx,
                             input logic [stc_pkg::WW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        case (idx)
            stc_pkg::CFG_TURN_W: turn_w = v;
            stc_pkg::CFG_HEAD_A: head_wa = v;
            stc_pkg::CFG_HEAD_B: head_wb = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push(input logic [31:0] a, b, c, e, f);
        t_segment s;
        s = '{a, b, c, e, f};
        seg_queue.push_back(s);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero length, small angle, axis directions
        push(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h0);
        push(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        push(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h40000000);
        push(32'h12345, 32'h6789, 32'h12345, 32'h6789, 32'h1234);
        push(32'h10000, 0, 0, 0, 0);
        push(32'h10000, 0, 0, 0, 32'd6835);
        push(32'h10000, 0, 0, 0, 32'd6836);
        push(32'h10000, 0, 0, 0, 32'h40000000);
        push(0, 0, 32'h10000, 0, 32'h80000000);
        push(0, 32'h10000, 0, 0, 32'h40000000);
        push(0, 0, 0, 32'h10000, 32'hC0000000);
        push(32'hFFFFFFFF, 0, 0, 0, 32'h20000000);
        push(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'hBFFFFFFF);
        drain();
        write_reg(stc_pkg::CFG_TURN_W, 24'hFFFFFF);
        write_reg(stc_pkg::CFG_HEAD_A, 24'hFFFFFF);
        write_reg(stc_pkg::CFG_HEAD_B, 24'hFFFFFF);
        write_reg(2'd3, 24'h123456);
        push(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h0);
        push(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h30000000);
        for (int i = 0; i < 100; i++) seg_queue.push_back(rand_segment(i % 2));
        drain();
        write_reg(stc_pkg::CFG_TURN_W, '0);
        write_reg(stc_pkg::CFG_HEAD_A, '0);
        write_reg(stc_pkg::CFG_HEAD_B, '0);
        for (int i = 0; i < 60; i++) seg_queue.push_back(rand_segment(i % 2));
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(stc_pkg::CFG_TURN_W, stc_pkg::WW'($urandom));
            write_reg(stc_pkg::CFG_HEAD_A, stc_pkg::WW'($urandom));
            write_reg(stc_pkg::CFG_HEAD_B, stc_pkg::WW'($urandom));
            if (ph == 1) begin
                quiet_src = 1; quiet_snk = 1;
            end else begin
                quiet_src = 0; quiet_snk = 0;
            end
            if (ph == 2) hold_snk = 1;
            for (int i = 0; i < 130; i++) seg_queue.push_back(rand_segment(i % 2));
            if (ph == 2) begin
                repeat (200) @(posedge i_clk);
                hold_snk = 0;
            end
            if (ph == 3) begin
                wait (seg_queue.size() < 60);
                src_pause = 1;
                wait (cost_queue.size() == 0);
                src_pause = 0;
            end
            drain();
        end
        if (n_errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
